/* rtl/allm_pkg.sv */
// ----------------------------------------------------------------------------
// allm_pkg
// Shared types and codes for the array linked list manager: command and
// status codes, stream layouts, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package allm_pkg;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LINK_W   = 5;

    // s_tdata: cmd, data_value, position; m_tdata: status, removed_value
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - STATUS_W - DATA_W;

    localparam logic [LINK_W-1:0] NIL_LINK = 5'd31;

    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_AFTER = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_FAIL,
        OP_TAKE,
        OP_HEAD_NEW,
        OP_START_WALK,
        OP_STEP,
        OP_LINK_CUR_NEW,
        OP_LINK_NEW_NEXT,
        OP_VICTIM_CUR,
        OP_VICTIM_AFTER,
        OP_UNLINK_TAIL,
        OP_BYPASS,
        OP_GIVE
    } op_t;

    // which slot the link read port looks at
    typedef enum logic [1:0] {
        RD_CUR,
        RD_FREE,
        RD_VIC
    } rd_sel_t;

    typedef struct packed {
        op_t                  op;
        rd_sel_t              rd_sel;
        logic [STATUS_W-1:0]  code;
        logic                 publish;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             list_empty;
        logic             free_empty;
        logic             pos_zero;
        logic             at_pos;
        logic             nxt_slot;
    } sts_t;

endpackage

/* rtl/allm_ram.sv */
// ----------------------------------------------------------------------------
// allm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module allm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/allm_ctrl.sv */
// ----------------------------------------------------------------------------
// allm_ctrl
// Command sequencer: accepts one word, steps the datapath through the
// chain walk and update for that command, then hands the result word over.
// ----------------------------------------------------------------------------
module allm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  allm_pkg::sts_t sts,
    output allm_pkg::ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_AP_HEAD,
        S_WALK_TAIL,
        S_SEEK,
        S_INS_TAKE,
        S_INS_LINK,
        S_INS_JOIN,
        S_WALK_DEL,
        S_DT_UNLINK,
        S_DEL_AFTER,
        S_DA_BYPASS,
        S_GIVE,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl.op        = allm_pkg::OP_NONE;
        ctl.rd_sel    = allm_pkg::RD_CUR;
        ctl.code      = allm_pkg::ST_OK;
        ctl.publish   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.op     = allm_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.cmd)
                    allm_pkg::CMD_CLEAR: begin
                        ctl.op     = allm_pkg::OP_CLEAR;
                        state_next = S_FIN;
                    end
                    allm_pkg::CMD_APPEND: begin
                        ctl.rd_sel = allm_pkg::RD_FREE;
                        if (sts.free_empty) begin
                            ctl.op     = allm_pkg::OP_FAIL;
                            ctl.code   = allm_pkg::ST_NO_FREE;
                            state_next = S_FIN;
                        end else begin
                            ctl.op     = allm_pkg::OP_TAKE;
                            state_next = S_AP_HEAD;
                        end
                    end
                    allm_pkg::CMD_INSERT, allm_pkg::CMD_DEL_AFTER: begin
                        if (sts.list_empty) begin
                            ctl.op     = allm_pkg::OP_FAIL;
                            ctl.code   = allm_pkg::ST_EMPTY;
                            state_next = S_FIN;
                        end else if (sts.pos_zero) begin
                            ctl.op     = allm_pkg::OP_FAIL;
                            ctl.code   = allm_pkg::ST_BAD_POS;
                            state_next = S_FIN;
                        end else begin
                            ctl.op     = allm_pkg::OP_START_WALK;
                            state_next = S_SEEK;
                        end
                    end
                    allm_pkg::CMD_DEL_TAIL: begin
                        if (sts.list_empty) begin
                            ctl.op     = allm_pkg::OP_FAIL;
                            ctl.code   = allm_pkg::ST_EMPTY;
                            state_next = S_FIN;
                        end else begin
                            ctl.op     = allm_pkg::OP_START_WALK;
                            state_next = S_WALK_DEL;
                        end
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_AP_HEAD: begin
                if (sts.list_empty) begin
                    ctl.op     = allm_pkg::OP_HEAD_NEW;
                    state_next = S_FIN;
                end else begin
                    ctl.op     = allm_pkg::OP_START_WALK;
                    state_next = S_WALK_TAIL;
                end
            end
            S_WALK_TAIL: begin
                if (sts.nxt_slot) begin
                    ctl.op = allm_pkg::OP_STEP;
                end else begin
                    ctl.op     = allm_pkg::OP_LINK_CUR_NEW;
                    state_next = S_FIN;
                end
            end
            S_SEEK: begin
                if (sts.at_pos) begin
                    state_next = (sts.cmd == allm_pkg::CMD_INSERT) ? S_INS_TAKE : S_DEL_AFTER;
                end else if (!sts.nxt_slot) begin
                    ctl.op     = allm_pkg::OP_FAIL;
                    ctl.code   = allm_pkg::ST_BAD_POS;
                    state_next = S_FIN;
                end else begin
                    ctl.op = allm_pkg::OP_STEP;
                end
            end
            S_INS_TAKE: begin
                ctl.rd_sel = allm_pkg::RD_FREE;
                if (sts.free_empty) begin
                    ctl.op     = allm_pkg::OP_FAIL;
                    ctl.code   = allm_pkg::ST_NO_FREE;
                    state_next = S_FIN;
                end else begin
                    ctl.op     = allm_pkg::OP_TAKE;
                    state_next = S_INS_LINK;
                end
            end
            S_INS_LINK: begin
                ctl.op     = allm_pkg::OP_LINK_NEW_NEXT;
                state_next = S_INS_JOIN;
            end
            S_INS_JOIN: begin
                ctl.op     = allm_pkg::OP_LINK_CUR_NEW;
                state_next = S_FIN;
            end
            S_WALK_DEL: begin
                if (sts.nxt_slot) begin
                    ctl.op = allm_pkg::OP_STEP;
                end else begin
                    ctl.op     = allm_pkg::OP_VICTIM_CUR;
                    state_next = S_DT_UNLINK;
                end
            end
            S_DT_UNLINK: begin
                ctl.op     = allm_pkg::OP_UNLINK_TAIL;
                state_next = S_GIVE;
            end
            S_DEL_AFTER: begin
                if (!sts.nxt_slot) begin
                    ctl.op     = allm_pkg::OP_FAIL;
                    ctl.code   = allm_pkg::ST_BAD_POS;
                    state_next = S_FIN;
                end else begin
                    ctl.op     = allm_pkg::OP_VICTIM_AFTER;
                    state_next = S_DA_BYPASS;
                end
            end
            S_DA_BYPASS: begin
                ctl.rd_sel = allm_pkg::RD_VIC;
                ctl.op     = allm_pkg::OP_BYPASS;
                state_next = S_GIVE;
            end
            S_GIVE: begin
                // registered value RAM read of the victim address is valid here
                ctl.op     = allm_pkg::OP_GIVE;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    ctl.publish   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

/* rtl/allm_dp.sv */
// ----------------------------------------------------------------------------
// allm_dp
// Datapath: link table, list and free heads, walk pointers, value RAM and
// the result register. Each cycle performs the one operation it is told.
// ----------------------------------------------------------------------------
module allm_dp #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [allm_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic [allm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  allm_pkg::ctl_t                  ctl,
    output allm_pkg::sts_t                  sts
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LW     = allm_pkg::LINK_W;
    localparam int DW     = allm_pkg::DATA_W;
    localparam int PW     = allm_pkg::POS_W;
    localparam int CW     = allm_pkg::CMD_W;
    localparam int SW     = allm_pkg::STATUS_W;

    logic [LW-1:0] link_reg [SLOT_COUNT];
    logic [LW-1:0] link_next [SLOT_COUNT];

    logic [CW-1:0]        cmd_reg, cmd_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [PW-1:0]        cnt_reg, cnt_next;
    logic [LW-1:0]        list_head_reg, list_head_next;
    logic [LW-1:0]        free_head_reg, free_head_next;
    logic [LW-1:0]        cur_reg, cur_next;
    logic [LW-1:0]        prev_reg, prev_next;
    logic [LW-1:0]        vic_reg, vic_next;
    logic [LW-1:0]        new_reg, new_next;
    logic [SW-1:0]        status_reg, status_next;
    logic signed [DW-1:0] removed_reg, removed_next;
    logic [SW-1:0]        out_status_reg;
    logic signed [DW-1:0] out_removed_reg;

    logic [LW-1:0]        rd_addr, rd_link, nxt;
    logic                 ram_we;
    logic [DW-1:0]        ram_rdata;

    function automatic logic is_slot(input logic [LW-1:0] s);
        return s < LW'(SLOT_COUNT);
    endfunction

    function automatic logic [SLOT_W-1:0] idx(input logic [LW-1:0] s);
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [LW-1:0] clear_link(input int i);
        return (i == SLOT_COUNT - 1) ? allm_pkg::NIL_LINK : LW'(i + 1);
    endfunction

    // single link read port; out-of-range links read as null
    always_comb begin
        case (ctl.rd_sel)
            allm_pkg::RD_FREE: rd_addr = free_head_reg;
            allm_pkg::RD_VIC:  rd_addr = vic_reg;
            default:           rd_addr = cur_reg;
        endcase
        rd_link = is_slot(rd_addr) ? link_reg[idx(rd_addr)] : allm_pkg::NIL_LINK;
        nxt     = is_slot(rd_link) ? rd_link : allm_pkg::NIL_LINK;
    end

    assign sts.cmd        = cmd_reg;
    assign sts.list_empty = !is_slot(list_head_reg);
    assign sts.free_empty = !is_slot(free_head_reg);
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.at_pos     = (cnt_reg == pos_reg);
    assign sts.nxt_slot   = is_slot(nxt);

    assign ram_we = (ctl.op == allm_pkg::OP_TAKE);

    always_comb begin
        link_next      = link_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        vic_next       = vic_reg;
        new_next       = new_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        case (ctl.op)
            allm_pkg::OP_LOAD: begin
                cmd_next     = s_tdata[CW-1:0];
                val_next     = s_tdata[CW+DW-1:CW];
                pos_next     = s_tdata[CW+DW+PW-1:CW+DW];
                status_next  = allm_pkg::ST_OK;
                removed_next = '0;
            end
            allm_pkg::OP_CLEAR: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    link_next[i] = clear_link(i);
                end
                list_head_next = allm_pkg::NIL_LINK;
                free_head_next = '0;
            end
            allm_pkg::OP_FAIL: begin
                status_next = ctl.code;
            end
            allm_pkg::OP_TAKE: begin
                new_next       = free_head_reg;
                free_head_next = nxt;
                if (is_slot(free_head_reg)) begin
                    link_next[idx(free_head_reg)] = allm_pkg::NIL_LINK;
                end
            end
            allm_pkg::OP_HEAD_NEW: begin
                list_head_next = new_reg;
            end
            allm_pkg::OP_START_WALK: begin
                cur_next  = list_head_reg;
                prev_next = allm_pkg::NIL_LINK;
                cnt_next  = PW'(1);
            end
            allm_pkg::OP_STEP: begin
                prev_next = cur_reg;
                cur_next  = nxt;
                cnt_next  = cnt_reg + PW'(1);
            end
            allm_pkg::OP_LINK_CUR_NEW: begin
                if (is_slot(cur_reg)) begin
                    link_next[idx(cur_reg)] = new_reg;
                end
            end
            allm_pkg::OP_LINK_NEW_NEXT: begin
                if (is_slot(new_reg)) begin
                    link_next[idx(new_reg)] = nxt;
                end
            end
            allm_pkg::OP_VICTIM_CUR: begin
                vic_next = cur_reg;
            end
            allm_pkg::OP_VICTIM_AFTER: begin
                vic_next = nxt;
            end
            allm_pkg::OP_UNLINK_TAIL: begin
                if (is_slot(prev_reg)) begin
                    link_next[idx(prev_reg)] = allm_pkg::NIL_LINK;
                end else begin
                    list_head_next = allm_pkg::NIL_LINK;
                end
            end
            allm_pkg::OP_BYPASS: begin
                if (is_slot(cur_reg)) begin
                    link_next[idx(cur_reg)] = nxt;
                end
            end
            allm_pkg::OP_GIVE: begin
                removed_next = ram_rdata;
                if (is_slot(vic_reg)) begin
                    link_next[idx(vic_reg)] = free_head_reg;
                    free_head_next          = vic_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                link_reg[i] <= clear_link(i);
            end
            list_head_reg <= allm_pkg::NIL_LINK;
            free_head_reg <= '0;
        end else begin
            link_reg      <= link_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        vic_reg     <= vic_next;
        new_reg     <= new_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if (ctl.publish) begin
            out_status_reg  <= status_reg;
            out_removed_reg <= removed_reg;
        end
    end

    allm_ram #(
        .WIDTH (DW),
        .DEPTH (SLOT_COUNT)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx(free_head_reg)),
        .wdata (val_reg),
        .raddr (idx(vic_reg)),
        .rdata (ram_rdata)
    );

    assign m_tdata = {{allm_pkg::M_PAD_W{1'b0}}, out_removed_reg, out_status_reg};

endmodule

/* rtl/array_linked_list_manager.sv */
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Singly linked list in a fixed slot store with a free list of unused slots.
// ----------------------------------------------------------------------------
// Usage:
//   One command word in on the s_ stream (clear, append, insert after N,
//   delete tail, delete after N), one result word out on the m_ stream
//   (status and removed value). Positions count from 1 at the head.
//   Commands run one at a time. The chain walk reads one link per cycle
//   from the link table. The next command is accepted as soon as the
//   result is in the output register, even while the receiver stalls
//   it; a second result waits in the sequencer until that register is
//   taken.
//   Reset (aresetn low, synchronous) empties the list, chains every slot
//   on the free list and drops any pending result. Stored values are not
//   cleared; a slot is always written before it is read.
// ----------------------------------------------------------------------------
module array_linked_list_manager #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [allm_pkg::S_TDATA_W-1:0] s_tdata,   // cmd[2:0], data_value[34:3], position[39:35]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [allm_pkg::M_TDATA_W-1:0] m_tdata    // status[1:0], removed_value[33:2], zero pad
);

    allm_pkg::ctl_t ctl;
    allm_pkg::sts_t sts;

    allm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    allm_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .ctl     (ctl),
        .sts     (sts)
    );

endmodule

/* rtl/allm_checker.sv */
// ----------------------------------------------------------------------------
// allm_checker
// Port-level checks for the linked list manager, bound to the top level.
// ----------------------------------------------------------------------------
module allm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [allm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [allm_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one command in flight: no accept right after an accept
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a command is in progress");

    // failed commands never report a removed value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != allm_pkg::ST_OK) |-> (m_tdata[33:2] == '0))
        else $error("removed value nonzero on error status");

    // reset drops any pending result
    a_rst_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind array_linked_list_manager allm_checker u_allm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/tb_array_linked_list_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_manager
// Self-checking bench for the slot-store linked list. A queue of command
// words feeds a clocked driver. Each accepted command runs through a local
// model of the list and free chain, and the model's answer is queued. A
// clocked monitor takes each result word and compares it with the oldest
// queued answer. The stimulus is a directed opening, then random commands
// whose positions follow the list length. The run has three idle mixes,
// one long receiver stall, and a sender pause between phases.
// ----------------------------------------------------------------------------
module tb_array_linked_list_manager;

    localparam int SLOTS      = 16;
    localparam int PHASE_CMDS = 700;
    localparam int CYCLE_CAP  = 1000000;
    localparam int STALL_AT   = 1800;   // result count that starts the long stall
    localparam int STALL_LEN  = 400;
    localparam int TAIL_WAIT  = 60;

    typedef logic [allm_pkg::CMD_W-1:0] CMD_t;

    typedef struct packed {
        logic [allm_pkg::CMD_W-1:0]         cmd;
        logic signed [allm_pkg::DATA_W-1:0] data_value;
        logic [allm_pkg::POS_W-1:0]         position;
    } list_cmd_t;

    typedef struct packed {
        logic [allm_pkg::STATUS_W-1:0]      status;
        logic signed [allm_pkg::DATA_W-1:0] removed_value;
    } list_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [allm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [allm_pkg::M_TDATA_W-1:0] m_tdata;

    array_linked_list_manager #(.SLOT_COUNT(SLOTS)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // List model: values, links, list head and free head
    // ------------------------------------------------------------------
    logic [allm_pkg::DATA_W-1:0] slot_val  [SLOTS];
    logic [allm_pkg::LINK_W-1:0] slot_link [SLOTS];
    logic [allm_pkg::LINK_W-1:0] head_slot;
    logic [allm_pkg::LINK_W-1:0] free_slot;

    function automatic bit is_slot(logic [allm_pkg::LINK_W-1:0] s);
        return s < SLOTS;
    endfunction

    function automatic logic [allm_pkg::LINK_W-1:0] link_after(
        logic [allm_pkg::LINK_W-1:0] s);
        if (!is_slot(s)) return allm_pkg::NIL_LINK;
        return is_slot(slot_link[s]) ? slot_link[s] : allm_pkg::NIL_LINK;
    endfunction

    function automatic void chain_reset();
        for (int i = 0; i < SLOTS; i++) slot_link[i] = allm_pkg::LINK_W'(i + 1);
        slot_link[SLOTS-1] = allm_pkg::NIL_LINK;
        head_slot = allm_pkg::NIL_LINK;
        free_slot = '0;
    endfunction

    function automatic logic [allm_pkg::LINK_W-1:0] slot_at_pos(
        logic [allm_pkg::POS_W-1:0] pos);
        logic [allm_pkg::LINK_W-1:0] cur;
        cur = head_slot;
        if (pos == 0 || !is_slot(cur)) return allm_pkg::NIL_LINK;
        for (int i = 1; i < pos; i++) begin
            cur = link_after(cur);
            if (!is_slot(cur)) return allm_pkg::NIL_LINK;
        end
        return cur;
    endfunction

    function automatic void free_push(logic [allm_pkg::LINK_W-1:0] s);
        if (!is_slot(s)) return;
        slot_link[s] = free_slot;
        free_slot = s;
    endfunction

    function automatic list_result_t apply_cmd(list_cmd_t c);
        list_result_t                r;
        logic [allm_pkg::LINK_W-1:0] cur, prev, s;
        r.status = allm_pkg::ST_OK;
        r.removed_value = '0;
        case (c.cmd)
            allm_pkg::CMD_CLEAR: begin
                chain_reset();
            end
            allm_pkg::CMD_APPEND: begin
                if (!is_slot(free_slot)) begin
                    r.status = allm_pkg::ST_NO_FREE;
                end else begin
                    s = free_slot;
                    free_slot = link_after(s);
                    slot_val[s] = c.data_value;
                    slot_link[s] = allm_pkg::NIL_LINK;
                    if (!is_slot(head_slot)) begin
                        head_slot = s;
                    end else begin
                        cur = head_slot;
                        for (int n = 0; n < SLOTS && is_slot(link_after(cur)); n++)
                            cur = link_after(cur);
                        slot_link[cur] = s;
                    end
                end
            end
            allm_pkg::CMD_INSERT: begin
                cur = slot_at_pos(c.position);
                if (!is_slot(head_slot)) begin
                    r.status = allm_pkg::ST_EMPTY;
                end else if (!is_slot(cur)) begin
                    r.status = allm_pkg::ST_BAD_POS;
                end else if (!is_slot(free_slot)) begin
                    r.status = allm_pkg::ST_NO_FREE;
                end else begin
                    s = free_slot;
                    free_slot = link_after(s);
                    slot_val[s] = c.data_value;
                    slot_link[s] = link_after(cur);
                    slot_link[cur] = s;
                end
            end
            allm_pkg::CMD_DEL_TAIL: begin
                if (!is_slot(head_slot)) begin
                    r.status = allm_pkg::ST_EMPTY;
                end else begin
                    prev = allm_pkg::NIL_LINK;
                    cur = head_slot;
                    for (int n = 0; n < SLOTS && is_slot(link_after(cur)); n++) begin
                        prev = cur;
                        cur = link_after(cur);
                    end
                    r.removed_value = slot_val[cur];
                    if (is_slot(prev)) slot_link[prev] = allm_pkg::NIL_LINK;
                    else head_slot = allm_pkg::NIL_LINK;
                    free_push(cur);
                end
            end
            allm_pkg::CMD_DEL_AFTER: begin
                cur = slot_at_pos(c.position);
                if (!is_slot(head_slot)) begin
                    r.status = allm_pkg::ST_EMPTY;
                end else if (!is_slot(cur) || !is_slot(link_after(cur))) begin
                    r.status = allm_pkg::ST_BAD_POS;
                end else begin
                    s = link_after(cur);
                    r.removed_value = slot_val[s];
                    slot_link[cur] = link_after(s);
                    free_push(s);
                end
            end
            default: ;  // unused codes leave everything alone
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    list_cmd_t    cmd_queue[$];
    list_result_t exp_results[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           err_count     = 0;

    function automatic void push_cmd(logic [allm_pkg::CMD_W-1:0] c,
                                     logic [allm_pkg::DATA_W-1:0] d,
                                     logic [allm_pkg::POS_W-1:0] p);
        list_cmd_t w;
        w.cmd = c;
        w.data_value = d;
        w.position = p;
        cmd_queue.push_back(w);
    endfunction

    function automatic logic [allm_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mode 0 grows the list, 1 shrinks it, 2 mixes; len tracks the length
    function automatic void push_random_cmd(inout int len, input int mode);
        logic [allm_pkg::CMD_W-1:0] c;
        logic [allm_pkg::POS_W-1:0] p;
        int                         r, p_app, p_ins, p_del;
        case (mode)
            0:       begin p_app = 45; p_ins = 82; p_del = 91; end
            1:       begin p_app = 10; p_ins = 22; p_del = 60; end
            default: begin p_app = 30; p_ins = 55; p_del = 78; end
        endcase
        r = $urandom_range(99);
        if (r < 2) c = allm_pkg::CMD_CLEAR;
        else if (r < 4) c = CMD_t'($urandom_range(7, allm_pkg::CMD_DEL_AFTER + 1));
        else begin
            r = $urandom_range(99);
            if (r < p_app) c = allm_pkg::CMD_APPEND;
            else if (r < p_ins) c = allm_pkg::CMD_INSERT;
            else if (r < p_del) c = allm_pkg::CMD_DEL_TAIL;
            else c = allm_pkg::CMD_DEL_AFTER;
        end
        if (len > 0 && $urandom_range(9) < 8)
            p = allm_pkg::POS_W'($urandom_range(len, 1));
        else
            p = allm_pkg::POS_W'($urandom_range(SLOTS, 0));
        push_cmd(c, pick_value(), p);
        case (c)
            allm_pkg::CMD_CLEAR:     len = 0;
            allm_pkg::CMD_APPEND:    if (len < SLOTS) len++;
            allm_pkg::CMD_INSERT:    if (len > 0 && p >= 1 && p <= len && len < SLOTS) len++;
            allm_pkg::CMD_DEL_TAIL:  if (len > 0) len--;
            allm_pkg::CMD_DEL_AFTER: if (len > 0 && p >= 1 && p < len) len--;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    list_cmd_t cur_cmd;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                exp_results.push_back(apply_cmd(cur_cmd));
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_cmd = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_cmd.position, cur_cmd.data_value, cur_cmd.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    list_result_t                  want;
    logic [allm_pkg::STATUS_W-1:0] got_status;
    logic [allm_pkg::DATA_W-1:0]   got_removed;
    int                            results_seen = 0;
    int                            stall_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_status  = m_tdata[allm_pkg::STATUS_W-1:0];
                got_removed = m_tdata[allm_pkg::STATUS_W +: allm_pkg::DATA_W];
                if (exp_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result word: status %0d removed %h",
                             $time, got_status, got_removed);
                end else begin
                    want = exp_results.pop_front();
                    if (got_status !== want.status) begin
                        err_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got_status);
                    end
                    if (got_removed !== want.removed_value) begin
                        err_count++;
                        $display("%0t: removed_value mismatch: expected %h, actual %h",
                                 $time, want.removed_value, got_removed);
                    end
                end
                results_seen++;
                if (results_seen == STALL_AT) stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    task automatic drain();
        while (cmd_queue.size() != 0 || s_tvalid || exp_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic random_phase(int s_pct, int r_pct);
        int len, mode;
        len = 0;
        mode = 2;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        push_cmd(allm_pkg::CMD_CLEAR, $urandom, '0);
        for (int i = 0; i < PHASE_CMDS; i++) begin
            if (i % 30 == 0) mode = $urandom_range(2);
            push_random_cmd(len, mode);
        end
        drain();
    endtask

    initial begin
        slot_val = '{default: '0};
        chain_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 75;
        // empty-list errors, then position checks on a short list
        push_cmd(allm_pkg::CMD_CLEAR,     $urandom,      5'd0);
        push_cmd(allm_pkg::CMD_DEL_TAIL,  $urandom,      5'd0);
        push_cmd(allm_pkg::CMD_DEL_AFTER, $urandom,      5'd1);
        push_cmd(allm_pkg::CMD_INSERT,    $urandom,      5'd1);
        push_cmd(allm_pkg::CMD_APPEND,    32'h8000_0000, 5'd0);
        push_cmd(allm_pkg::CMD_INSERT,    $urandom,      5'd0);
        push_cmd(allm_pkg::CMD_INSERT,    $urandom,      5'd2);
        push_cmd(allm_pkg::CMD_INSERT,    32'h7fff_ffff, 5'd1);
        push_cmd(allm_pkg::CMD_DEL_AFTER, $urandom,      5'd2);
        push_cmd(allm_pkg::CMD_DEL_AFTER, $urandom,      5'd0);
        push_cmd(allm_pkg::CMD_DEL_AFTER, $urandom,      5'd1);
        push_cmd(allm_pkg::CMD_DEL_TAIL,  $urandom,      5'd31);
        push_cmd(CMD_t'(allm_pkg::CMD_DEL_AFTER + 1), $urandom, 5'd3);
        push_cmd(CMD_t'(7),               32'hffff_ffff, 5'd31);
        // fill the store, then hit the full-store cases
        for (int i = 0; i < SLOTS; i++) push_cmd(allm_pkg::CMD_APPEND, $urandom, 5'd0);
        push_cmd(allm_pkg::CMD_APPEND,    $urandom,      5'd0);
        push_cmd(allm_pkg::CMD_INSERT,    $urandom,      5'd16);
        push_cmd(allm_pkg::CMD_INSERT,    $urandom,      5'd0);
        push_cmd(allm_pkg::CMD_DEL_AFTER, $urandom,      5'd16);
        push_cmd(allm_pkg::CMD_DEL_AFTER, $urandom,      5'd15);
        push_cmd(allm_pkg::CMD_DEL_TAIL,  $urandom,      5'd0);
        drain();

        random_phase(17, 75);
        random_phase(75, 17);
        random_phase(0, 0);

        repeat (TAIL_WAIT) @(negedge aclk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        repeat (CYCLE_CAP) @(posedge aclk);
        $display("%0t: cycle limit reached", $time);
        $display("FAIL");
        $finish;
    end

endmodule

/* array_linked_list_manager.f */
rtl/allm_pkg.sv
rtl/allm_ram.sv
rtl/allm_ctrl.sv
rtl/allm_dp.sv
rtl/array_linked_list_manager.sv
rtl/allm_checker.sv
sim/tb_array_linked_list_manager.sv
